@@ rtl/nlc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the numeric literal classifier: parse phase codes, result class
// codes, character constants and the byte classification helpers.
// No dependencies.
package nlc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned CLASS_W = 2;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic [CLASS_W-1:0] t_class;

    // Parse phases.
    localparam t_phase PH_LEAD = 4'd0;  // leading blanks
    localparam t_phase PH_SIGN = 4'd1;  // after sign
    localparam t_phase PH_ZERO = 4'd2;  // first digit was zero
    localparam t_phase PH_INT  = 4'd3;  // integer digits
    localparam t_phase PH_HEX  = 4'd4;  // hex digits
    localparam t_phase PH_FRAC = 4'd5;  // fraction digits

    // Result classes.
    localparam t_class CLS_NONE = 2'd0;
    localparam t_class CLS_INT  = 2'd1;
    localparam t_class CLS_HEX  = 2'd2;
    localparam t_class CLS_DEC  = 2'd3;

    // Characters of interest.
    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_PLUS  = 8'h2B;
    localparam t_byte CH_MINUS = 8'h2D;
    localparam t_byte CH_POINT = 8'h2E;
    localparam t_byte CH_0     = 8'h30;
    localparam t_byte CH_9     = 8'h39;
    localparam t_byte CH_UA    = 8'h41;
    localparam t_byte CH_UF    = 8'h46;
    localparam t_byte CH_UX    = 8'h58;
    localparam t_byte CH_LA    = 8'h61;
    localparam t_byte CH_LF    = 8'h66;
    localparam t_byte CH_LX    = 8'h78;

    function automatic logic is_dec(input t_byte c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_hexd(input t_byte c);
        return is_dec(c) || ((c >= CH_LA) && (c <= CH_LF)) ||
               ((c >= CH_UA) && (c <= CH_UF));
    endfunction

endpackage

@@ rtl/numeric_literal_classifier_top.sv @@
`timescale 1ns / 1ps
// Numeric literal classifier: byte-stream parser with a registered result.
// Depends on nlc_pkg.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall) carries one character per beat.
//   A beat with i_end_of_string high, or with a zero byte, ends the string.
// - Output channel (o_out_valid / i_out_stall) carries one class per string:
//   0 not numeric, 1 decimal integer, 2 hexadecimal, 3 decimal with a point.
// - Every input beat updates the parse state in the cycle it is accepted.
//   A terminating beat loads the result register, so the class appears on
//   o_number_class with o_out_valid high in the cycle after the terminator is accepted.
// - Throughput is one beat per cycle while o_in_stall is low; the single
//   per-byte state update between the parse registers is the only path an item takes.
// - The output register holds a result until the receiver takes it. While
//   a result waits and i_out_stall is high, o_in_stall is raised; otherwise
//   input beats keep flowing, including while a result is being taken.
// - Reset (synchronous, active low) returns the parser to the leading-blank
//   phase with all flags clear and empties the output register.
module numeric_literal_classifier_top
    import nlc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_end_of_string,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [CLASS_W-1:0] o_number_class
);

    t_phase r_phase, n_phase;
    logic   r_hex,   n_hex;
    logic   r_point, n_point;
    logic   r_rej,   n_rej;
    logic   r_out_valid, n_out_valid;
    t_class r_class, n_class;

    logic   in_acc;
    logic   term;
    t_class final_class;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign term       = i_end_of_string | (i_text_byte == CH_NUL);

    always_comb begin
        if (r_rej || (r_phase < PH_ZERO) || (r_phase > PH_FRAC)) begin
            final_class = CLS_NONE;
        end else if (r_hex) begin
            final_class = CLS_HEX;
        end else if (r_point) begin
            final_class = CLS_DEC;
        end else begin
            final_class = CLS_INT;
        end
    end

    // Per-byte parse step.
    always_comb begin
        n_phase = r_phase;
        n_hex   = r_hex;
        n_point = r_point;
        n_rej   = r_rej;
        if (in_acc) begin
            if (term) begin
                n_phase = PH_LEAD;
                n_hex   = 1'b0;
                n_point = 1'b0;
                n_rej   = 1'b0;
            end else if (!r_rej) begin
                case (r_phase)
                    PH_LEAD, PH_SIGN: begin
                        if ((r_phase == PH_LEAD) &&
                            ((i_text_byte == CH_SPACE) || (i_text_byte == CH_TAB))) begin
                            n_phase = PH_LEAD;
                        end else if ((r_phase == PH_LEAD) &&
                            ((i_text_byte == CH_PLUS) || (i_text_byte == CH_MINUS))) begin
                            n_phase = PH_SIGN;
                        end else if (i_text_byte == CH_0) begin
                            n_phase = PH_ZERO;
                        end else if (is_dec(i_text_byte)) begin
                            n_phase = PH_INT;
                        end else if (i_text_byte == CH_POINT) begin
                            n_point = 1'b1;
                            n_phase = PH_FRAC;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    PH_ZERO, PH_INT: begin
                        if ((r_phase == PH_ZERO) &&
                            ((i_text_byte == CH_LX) || (i_text_byte == CH_UX))) begin
                            n_hex   = 1'b1;
                            n_phase = PH_HEX;
                        end else if (is_dec(i_text_byte)) begin
                            n_phase = PH_INT;
                        end else if (i_text_byte == CH_POINT) begin
                            n_point = 1'b1;
                            n_phase = PH_FRAC;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    PH_HEX: begin
                        if (!is_hexd(i_text_byte)) begin
                            n_rej = 1'b1;
                        end
                    end
                    PH_FRAC: begin
                        if (!is_dec(i_text_byte)) begin
                            n_rej = 1'b1;
                        end
                    end
                    default: begin
                        n_rej = 1'b1;
                    end
                endcase
            end
        end
    end

    // Result register: loads on a terminator, clears when the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        n_class     = r_class;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (in_acc && term) begin
            n_out_valid = 1'b1;
            n_class     = final_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_hex       <= 1'b0;
            r_point     <= 1'b0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hex       <= n_hex;
            r_point     <= n_point;
            r_rej       <= n_rej;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_class <= n_class;
    end

    assign o_out_valid    = r_out_valid;
    assign o_number_class = r_class;

    // A terminator always leaves the parser back in its idle state.
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && term) |=> (r_phase == PH_LEAD) && !r_hex && !r_point && !r_rej)
        else $error("parser state not cleared after terminator");

    // A terminator always produces a result beat.
    a_term_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && term) |=> r_out_valid)
        else $error("no result after terminator");

    // The hex flag is only ever set together with the hex phase.
    a_hex_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex |-> (r_phase == PH_HEX))
        else $error("hex flag outside hex phase");

    // The point flag is only ever set together with the fraction phase.
    a_point_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_point |-> (r_phase == PH_FRAC))
        else $error("point flag outside fraction phase");

endmodule
